### hw/rtl/oezl_pkg.sv
`default_nettype none
package oezl_pkg;

	localparam int ZONE_CNT = 64;
	localparam int ZONE_W = $clog2(ZONE_CNT);
	localparam int WORDS_PER_ZONE = 17;
	localparam int WORD_W = 5;
	localparam int MEM_DEPTH = ZONE_CNT * WORDS_PER_ZONE;
	localparam int MEM_AW = $clog2(MEM_DEPTH);
	localparam int ACC_W = 36;
	localparam int SUM_W = 50;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [WORD_W-1:0] W_SYS = WORD_W'(0);
	localparam logic [WORD_W-1:0] W_DMG = WORD_W'(1);
	localparam logic [WORD_W-1:0] W_ROT = WORD_W'(2);
	localparam logic [WORD_W-1:0] W_ROT1 = WORD_W'(5);
	localparam logic [WORD_W-1:0] W_ROT2 = WORD_W'(8);
	localparam logic [WORD_W-1:0] W_TRN = WORD_W'(11);
	localparam logic [WORD_W-1:0] W_INV = WORD_W'(14);
	localparam logic [WORD_W-1:0] W_LAST = WORD_W'(WORDS_PER_ZONE - 1);
	localparam logic [WORD_W-1:0] EVAL_STEP = WORD_W'(WORDS_PER_ZONE + 4);

	localparam logic [23:0] TERM_SAT = 24'h800000;
	localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(1) << 44;

	typedef struct packed {
		logic [1:0]         operation;
		logic [5:0]         entry_index;
		logic [4:0]         word_index;
		logic [31:0]        word_value;
		logic [31:0]        system_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] required_damage;
		logic               check_damage;
	} cmd_t;

	typedef struct packed {
		logic               hit;
		logic [5:0]         zone_index;
		logic signed [31:0] zone_damage;
	} res_t;

	typedef struct packed {
		logic              issue;
		logic [WORD_W-1:0] word;
	} rd_ctl_t;

	typedef struct packed {
		logic [31:0]        sys;
		logic signed [31:0] dmg;
		logic               contained;
	} zone_stat_t;

endpackage
`default_nettype wire

### hw/rtl/oriented_ellipsoid_zone_lookup.sv
// Zone table of 64 oriented ellipsoids, 17 words each, in one single-port-read RAM.
// A load writes one word (writing word 0 marks the zone valid); a clear drops all
// valid bits at once. A query walks the zones in order: an invalid zone is skipped,
// a valid zone has its 17 words read from the RAM read port and is checked once the
// read and arithmetic pipeline has drained, and the walk stops at the first match.
// One transaction is in work at a time; the result register lets the next command
// be taken while a result waits.
`default_nettype none
module oriented_ellipsoid_zone_lookup import oezl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;
	localparam logic [ZONE_W-1:0] ZONE_LAST = ZONE_W'(ZONE_CNT - 1);

	logic [1:0]          state_q;
	logic [ZONE_CNT-1:0] zone_vld_q;
	logic [ZONE_W-1:0]   zone_q;
	logic [WORD_W-1:0]   step_q;
	cmd_t                qry_q;
	res_t                pend_q;
	logic                res_valid_q;
	res_t                res_q;

	logic                accept, wr_en, match, res_load;
	logic [MEM_AW-1:0]   waddr, raddr;
	logic [31:0]         rdata;
	rd_ctl_t             ctl;
	zone_stat_t          stat;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept = cmd_valid && !cmd_stall;
	assign wr_en = accept && (cmd.operation == OP_LOAD)
		&& (int'(cmd.entry_index) < ZONE_CNT) && (cmd.word_index <= W_LAST);
	assign waddr = MEM_AW'(cmd.entry_index) * MEM_AW'(WORDS_PER_ZONE)
		+ MEM_AW'(cmd.word_index);
	assign raddr = MEM_AW'(zone_q) * MEM_AW'(WORDS_PER_ZONE) + MEM_AW'(step_q);
	assign res_load = (state_q == ST_RESP) && (!res_valid_q || !res_stall);

	assign ctl.issue = (state_q == ST_SCAN) && (step_q <= W_LAST)
		&& ((step_q != W_SYS) || zone_vld_q[zone_q]);
	assign ctl.word = step_q;

	assign match = (stat.sys == qry_q.system_id)
		&& (!qry_q.check_damage || (stat.dmg > qry_q.required_damage))
		&& stat.contained;

	oezl_ram #(
		.WIDTH(32),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(cmd.word_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	oezl_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.rdata (rdata),
		.pos_x (qry_q.pos_x),
		.pos_y (qry_q.pos_y),
		.pos_z (qry_q.pos_z),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			zone_vld_q <= '0;
			zone_q <= '0;
			step_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.operation == OP_QUERY) begin
							zone_q <= '0;
							step_q <= '0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
						if (cmd.operation == OP_CLEAR) begin
							zone_vld_q <= '0;
						end
						if (wr_en && (cmd.word_index == W_SYS)) begin
							zone_vld_q[cmd.entry_index] <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (((step_q == W_SYS) && !zone_vld_q[zone_q])
						|| ((step_q == EVAL_STEP) && !match)) begin
						step_q <= '0;
						if (zone_q == ZONE_LAST) begin
							state_q <= ST_RESP;
						end else begin
							zone_q <= zone_q + 1'b1;
						end
					end else if (step_q == EVAL_STEP) begin
						state_q <= ST_RESP;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q <= cmd;
			pend_q <= '0;
		end
		if ((state_q == ST_SCAN) && (step_q == EVAL_STEP) && match) begin
			pend_q.hit <= 1'b1;
			pend_q.zone_index <= 6'(zone_q);
			pend_q.zone_damage <= stat.dmg;
		end
		if (res_load) begin
			res_q <= pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> step_q <= EVAL_STEP)
		else $error("scan step past evaluation");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.zone_index == '0 && res.zone_damage == '0)
		else $error("miss result carries data");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE && !ctl.issue)
		else $error("table write during scan");
endmodule
`default_nettype wire

### hw/rtl/oezl_ram.sv
`default_nettype none
module oezl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/oezl_datapath.sv
`default_nettype none
module oezl_datapath import oezl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rd_ctl_t            ctl,
	input  wire logic [31:0]        rdata,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	output zone_stat_t              stat
);
	logic                     a_vld_q;
	logic [WORD_W-1:0]        a_word_q;
	logic signed [ACC_W-1:0]  acc_q [3];
	logic [31:0]              sys_q;
	logic signed [31:0]       dmg_q;
	logic [SUM_W-1:0]         sum_q;

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     lin_s1, inv_s1;
	logic [1:0]               col_s1;
	logic signed [63:0]       prod_s1;
	logic [63:0]              pl_s1;
	logic [35:0]              ph_s1;
	logic [23:0]              t_s2;
	logic [47:0]              sq_s3;

	logic                     is_rot, is_trn, is_inv;
	logic [WORD_W-1:0]        off;
	logic [1:0]               col;
	logic signed [31:0]       pos_sel;
	logic signed [ACC_W-1:0]  acc_sel;
	logic [ACC_W-1:0]         mag;
	logic [67:0]              full;
	logic [23:0]              term;
	logic                     clr;

	assign clr = ctl.issue && (ctl.word == W_SYS);

	always_comb begin
		is_rot = (a_word_q >= W_ROT) && (a_word_q < W_TRN);
		is_trn = (a_word_q >= W_TRN) && (a_word_q < W_INV);
		is_inv = (a_word_q >= W_INV);
		pos_sel = pos_x;
		if (a_word_q >= W_INV) begin
			off = a_word_q - W_INV;
		end else if (a_word_q >= W_TRN) begin
			off = a_word_q - W_TRN;
		end else if (a_word_q >= W_ROT2) begin
			off = a_word_q - W_ROT2;
			pos_sel = pos_z;
		end else if (a_word_q >= W_ROT1) begin
			off = a_word_q - W_ROT1;
			pos_sel = pos_y;
		end else begin
			off = a_word_q - W_ROT;
		end
		col = off[1:0];
		acc_sel = acc_q[col];
		mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
	end

	always_comb begin
		full = {ph_s1, 32'b0} + 68'(pl_s1);
		term = (|full[67:45]) ? TERM_SAT : {1'b0, full[44:22]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			a_vld_q <= ctl.issue;
			vld_s1 <= a_vld_q;
			vld_s2 <= vld_s1 && inv_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_word_q <= ctl.word;
		lin_s1 <= is_rot || is_trn;
		inv_s1 <= is_inv;
		col_s1 <= col;
		if (is_trn) begin
			prod_s1 <= {{2{rdata[31]}}, rdata, 30'b0};
		end else begin
			prod_s1 <= pos_sel * $signed(rdata);
		end
		pl_s1 <= mag[31:0] * rdata;
		ph_s1 <= mag[ACC_W-1:32] * rdata;
		if (a_vld_q && (a_word_q == W_SYS)) begin
			sys_q <= rdata;
		end
		if (a_vld_q && (a_word_q == W_DMG)) begin
			dmg_q <= $signed(rdata);
		end
		t_s2 <= term;
		sq_s3 <= t_s2 * t_s2;
		if (clr) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
			sum_q <= '0;
		end else begin
			if (vld_s1 && lin_s1) begin
				acc_q[col_s1] <= acc_q[col_s1] + ACC_W'(prod_s1 >>> 30);
			end
			if (vld_s3) begin
				sum_q <= sum_q + SUM_W'(sq_s3);
			end
		end
	end

	assign stat.sys = sys_q;
	assign stat.dmg = dmg_q;
	assign stat.contained = (sum_q <= SUM_LIMIT);
endmodule
`default_nettype wire

### tb/tb_oriented_ellipsoid_zone_lookup.sv
`default_nettype none
module tb_oriented_ellipsoid_zone_lookup;
	import oezl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class zone_scoreboard;
		bit          valid_bits [ZONE_CNT];
		logic [31:0] words [ZONE_CNT][WORDS_PER_ZONE];
		res_t        pending [$];
		int          errors;

		function new();
			foreach (valid_bits[i]) valid_bits[i] = 0;
			foreach (words[i, j]) words[i][j] = '0;
			errors = 0;
		endfunction

		function longint floor_div30(longint v);
			return v >>> 30;
		endfunction

		function longint unsigned axis_term(longint loc, logic [31:0] k);
			longint unsigned mag;
			longint unsigned t;
			logic [127:0] prod;
			if (k == 0)
				return 0;
			mag = (loc < 0) ? longint'(-loc) : longint'(loc);
			prod = 128'(mag) * 128'(k);
			if (prod > 128'((64'd1 << 45) - 1))
				return 64'd1 << 23;
			t = 64'(prod) >> 22;
			return (t > (64'd1 << 23)) ? (64'd1 << 23) : t;
		endfunction

		function bit inside_zone(int z, cmd_t c);
			longint p [3];
			longint loc;
			longint unsigned sum;
			longint unsigned t;
			p[0] = c.pos_x;
			p[1] = c.pos_y;
			p[2] = c.pos_z;
			sum = 0;
			for (int a = 0; a < 3; a++) begin
				loc = longint'($signed(words[z][11 + a]));
				for (int r = 0; r < 3; r++)
					loc += floor_div30(p[r] * longint'($signed(words[z][2 + 3 * r + a])));
				t = axis_term(loc, words[z][14 + a]);
				sum += t * t;
			end
			return sum <= (64'd1 << 44);
		endfunction

		function void note_command(cmd_t c);
			res_t r;
			r = '0;
			case (c.operation)
				OP_LOAD: begin
					if (c.entry_index < ZONE_CNT && c.word_index < WORDS_PER_ZONE) begin
						words[c.entry_index][c.word_index] = c.word_value;
						if (c.word_index == W_SYS)
							valid_bits[c.entry_index] = 1;
					end
				end
				OP_CLEAR: begin
					foreach (valid_bits[i]) valid_bits[i] = 0;
				end
				OP_QUERY: begin
					for (int z = 0; z < ZONE_CNT; z++) begin
						if (!valid_bits[z] || words[z][0] != c.system_id)
							continue;
						if (c.check_damage && !($signed(words[z][1]) > c.required_damage))
							continue;
						if (inside_zone(z, c)) begin
							r.hit = 1;
							r.zone_index = z[5:0];
							r.zone_damage = words[z][1];
							break;
						end
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit %0d want %0d", got.hit, want.hit));
			if (got.zone_index !== want.zone_index)
				report($sformatf("zone_index %0d want %0d", got.zone_index, want.zone_index));
			if (got.zone_damage !== want.zone_damage)
				report($sformatf("zone_damage %0d want %0d", got.zone_damage, want.zone_damage));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 0;
	res_t res;

	zone_scoreboard board = new();
	bit quiet = 0;
	bit hold_long = 0;
	int idle_cycles = 0;
	bit zone_loaded [ZONE_CNT];
	bit [31:0] system_pool [4] = '{32'd7, 32'd8, 32'hFFFF_FFFF, 32'd0};

	oriented_ellipsoid_zone_lookup dut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(res);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("FAIL oriented_ellipsoid_zone_lookup");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				res_stall <= 1;
				repeat (400) @(posedge clk);
				hold_long = 0;
				res_stall <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 5);
				res_stall <= 1;
				repeat (n - 1) @(posedge clk);
			end else
				res_stall <= 0;
		end
	end

	task send(cmd_t c);
		int n;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 5);
			cmd_valid <= 0;
			repeat (n) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1;
		do @(posedge clk); while (cmd_stall);
		board.note_command(c);
	endtask

	task load_word(int e, int w, logic [31:0] v);
		cmd_t c;
		c = '0;
		c.operation = OP_LOAD;
		c.entry_index = 6'(e);
		c.word_index = 5'(w);
		c.word_value = v;
		c.system_id = $urandom;
		send(c);
		if (e < ZONE_CNT && w == 0)
			zone_loaded[e] = 1;
	endtask

	task load_zone(int e, logic [31:0] sys, logic [31:0] dmg, bit axis_aligned);
		real ang;
		logic signed [31:0] cs, sn;
		load_word(e, 0, sys);
		load_word(e, 1, dmg);
		ang = ($urandom_range(0, 628)) / 100.0;
		cs = $rtoi($cos(ang) * 1073741823.0);
		sn = $rtoi($sin(ang) * 1073741823.0);
		if (axis_aligned) begin
			cs = 32'sd1 << 30;
			sn = 0;
		end
		load_word(e, 2, cs);
		load_word(e, 3, -sn);
		load_word(e, 4, 0);
		load_word(e, 5, sn);
		load_word(e, 6, cs);
		load_word(e, 7, 0);
		load_word(e, 8, 0);
		load_word(e, 9, 0);
		load_word(e, 10, 32'sd1 << 30);
		for (int a = 0; a < 3; a++)
			load_word(e, 11 + a, $signed($urandom_range(0, 4000)) - 2000);
		for (int a = 0; a < 3; a++)
			load_word(e, 14 + a, ($urandom_range(0, 9) == 0) ? 32'd0 :
				$urandom_range(1 << 20, 1 << 26));
	endtask

	task query(logic [31:0] sys, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] req, bit chk);
		cmd_t c;
		c = '0;
		c.operation = OP_QUERY;
		c.entry_index = 6'($urandom);
		c.word_index = 5'($urandom);
		c.word_value = $urandom;
		c.system_id = sys;
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		c.required_damage = req;
		c.check_damage = chk;
		send(c);
	endtask

	task simple(logic [1:0] op);
		cmd_t c;
		c = '0;
		c.operation = op;
		c.word_value = $urandom;
		send(c);
	endtask

	task drain;
		cmd_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function logic signed [31:0] near_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			default: return $signed($urandom_range(0, 8000)) - 4000;
		endcase
	endfunction

	task zone_rewrite;
		int e;
		e = $urandom_range(0, ZONE_CNT - 1);
		load_zone(e, system_pool[$urandom_range(0, 3)], $urandom, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int sent;
		bit drained;
		bit held;
		drained = 0;
		held = 0;
		foreach (zone_loaded[i]) zone_loaded[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		load_zone(0, 32'd7, 32'sd100, 1);
		load_zone(63, 32'd7, 32'sh7FFF_FFFF, 0);
		load_zone(5, 32'hFFFF_FFFF, 32'sh8000_0000, 1);
		load_word(64 - 1 + 1 - 64 + 64 - 1, 20, 32'hFFFF_FFFF);
		load_word(63, 31, 32'h0);
		query(32'd7, 0, 0, 0, 0, 0);
		query(32'd7, 0, 0, 0, 32'sd100, 1);
		query(32'd7, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
		query(32'hFFFF_FFFF, 0, 0, 0, 32'sh8000_0000, 1);
		query(32'd9, 0, 0, 0, 0, 0);
		simple(OP_NONE);
		simple(OP_CLEAR);
		query(32'd7, 0, 0, 0, 0, 0);
		load_word(0, 0, 32'd7);
		query(32'd7, 10, -10, 3, 32'sh8000_0000, 1);
		drain();

		sent = 0;
		while (sent < 1350) begin
			if (sent > 1150)
				quiet = 1;
			if (!drained && sent >= 300) begin
				drained = 1;
				drain();
			end
			if (!held && sent >= 500) begin
				held = 1;
				hold_long = 1;
			end
			case ($urandom_range(0, 19))
				0, 1: begin
					zone_rewrite();
					sent += 17;
				end
				2: begin
					load_word($urandom_range(0, ZONE_CNT - 1), $urandom_range(17, 31), $urandom);
					sent++;
				end
				3: begin
					if ($urandom_range(0, 3) == 0) simple(OP_CLEAR);
					else simple(OP_NONE);
					sent++;
				end
				default: begin
					query(system_pool[$urandom_range(0, 3)], near_coord(), near_coord(),
						near_coord(), $urandom, 1'($urandom_range(0, 1)));
					sent++;
				end
			endcase
		end
		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("PASS oriented_ellipsoid_zone_lookup");
		else
			$display("FAIL oriented_ellipsoid_zone_lookup");
		$finish;
	end
endmodule
`default_nettype wire
